>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// concurrent assertion wrappers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define SWS_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expression must never be true outside reset
`define SWS_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define SWS_ASSERT(label, clk, rst_n, prop, msg)
`define SWS_NEVER(label, clk, rst_n, expr, msg)

`endif

`endif

>>> rtl/swsfr_pkg.sv
// ----------------------------------------------------------------------------
// swsfr_pkg
// types, codes and sizes for the sliding window sender
// ----------------------------------------------------------------------------
`default_nettype none

package swsfr_pkg;

	// sequence space
	localparam int SEQ_BITS  = 8;
	localparam int SEQ_DEPTH = 1 << SEQ_BITS;

	// duplicate ack counters
	localparam int COUNT_BITS = 3;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX     = '1;
	localparam logic [COUNT_BITS-1:0] DUP_THRESHOLD = COUNT_BITS'(3);

	// window size register
	localparam int WINDOW_BITS = 7;
	localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = WINDOW_BITS'(4);

	typedef logic [SEQ_BITS-1:0]   seq_t;
	typedef logic [COUNT_BITS-1:0] count_t;

	// command codes
	localparam logic [1:0] CMD_SEND   = 2'd0;
	localparam logic [1:0] CMD_ACK    = 2'd1;
	localparam logic [1:0] CMD_EXPIRY = 2'd2;

	// transmit kinds
	localparam logic [1:0] TX_NONE  = 2'd0;
	localparam logic [1:0] TX_NEW   = 2'd1;
	localparam logic [1:0] TX_RETRY = 2'd2;

	// timer actions
	localparam logic [1:0] TMR_NONE    = 2'd0;
	localparam logic [1:0] TMR_START   = 2'd1;
	localparam logic [1:0] TMR_STOP    = 2'd2;
	localparam logic [1:0] TMR_RESTART = 2'd3;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] ack_number;
		logic       checksum_ok;
		logic [7:0] expired_seq;
	} in_item_t;

	typedef struct packed {
		logic       accepted;
		logic [1:0] transmit_kind;
		logic [7:0] transmit_seq;
		logic [1:0] timer_action;
		logic [7:0] timer_seq;
		logic [7:0] base_now;
	} out_item_t;

endpackage

`default_nettype wire

>>> rtl/sliding_window_sender_fast_retransmit.sv
// ----------------------------------------------------------------------------
// sliding_window_sender_fast_retransmit
// sender side of a tcp-style sliding window with fast retransmit
// ----------------------------------------------------------------------------
// Takes one item per clock unless stalled: a send request, an arriving cumulative ack or a
// timer expiry, and returns exactly one result item for each, carrying the
// transmit command, the timer command and the window base after the item.
// An item accepted at one edge has its result in the output register at the
// next edge at the earliest; the unstalled rate is one item per cycle, set by
// the read-modify-write of the duplicate ack count table, whose registered
// read is issued at acceptance and whose write-back is forwarded to the
// following item. The count table clears at once on reset through one valid
// flag per entry, so there is no clearing pass. Writing window_size sets the
// window end to base plus size; write it only while no item is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_sender_fast_retransmit
	import swsfr_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	// window size register
	input  logic                   cfg_wr_en,
	input  logic [WINDOW_BITS-1:0] cfg_wr_data,
	// input items
	input  logic                   in_valid,
	output logic                   in_stall,
	input  in_item_t               in_data,
	// result items
	output logic                   out_valid,
	input  logic                   out_stall,
	output out_item_t              out_data
);

	`include "assert_macros.svh"

	// handshake and stage control
	logic      in_accept;
	logic      s1_valid_q;
	logic      s1_fire;
	logic      out_valid_q;
	in_item_t  in_s1;
	out_item_t out_q;

	// sender state
	seq_t next_seq_q;
	seq_t base_q;
	seq_t end_q;
	logic timer_q;

	// count table access
	logic [SEQ_DEPTH-1:0] cnt_vld_q;
	logic   cnt_vld_s1;
	logic   fwd_hit_s1;
	count_t fwd_data_s1;
	count_t ram_rdata;
	seq_t   rd_addr;
	logic   wr_req;
	logic   wr_en;
	seq_t   wr_addr;
	count_t wr_data;

	// single pass logic
	seq_t      ack_s1;
	seq_t      exp_s1;
	seq_t      outstanding;
	seq_t      wnd_span;
	seq_t      d_ack;
	seq_t      d_exp;
	logic      at_or_below;
	count_t    cnt_cur;
	count_t    cnt_inc;
	seq_t      next_seq_d;
	seq_t      base_d;
	seq_t      end_d;
	logic      timer_d;
	out_item_t res;

	// stage moves on when the output register is free or being emptied
	assign s1_fire   = s1_valid_q && (!out_valid_q || !out_stall);
	assign in_stall  = s1_valid_q && !s1_fire;
	assign in_accept = in_valid && !in_stall;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// count table read is launched by the arriving item
	assign rd_addr = seq_t'(in_data.ack_number);
	assign wr_en   = wr_req && s1_fire;

	swsfr_ram #(
		.WIDTH (COUNT_BITS),
		.DEPTH (SEQ_DEPTH)
	) u_cnt_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (in_accept),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	always_comb begin
		ack_s1      = seq_t'(in_s1.ack_number);
		exp_s1      = seq_t'(in_s1.expired_seq);
		// serial distances from the window base
		outstanding = next_seq_q - base_q;
		wnd_span    = end_q - base_q;
		d_ack       = ack_s1 - base_q;
		d_exp       = exp_s1 - base_q;
		at_or_below = (d_ack == '0) || d_ack[SEQ_BITS-1];

		// forwarded write from the previous item wins over the ram word
		if (fwd_hit_s1) begin
			cnt_cur = fwd_data_s1;
		end else if (cnt_vld_s1) begin
			cnt_cur = ram_rdata;
		end else begin
			cnt_cur = '0;
		end
		// saturating bump
		cnt_inc = (cnt_cur != COUNT_MAX) ? cnt_cur + COUNT_BITS'(1) : cnt_cur;

		next_seq_d = next_seq_q;
		base_d     = base_q;
		end_d      = end_q;
		timer_d    = timer_q;
		wr_req     = 1'b0;
		wr_addr    = ack_s1;
		wr_data    = cnt_inc;
		res        = '0;

		case (in_s1.command)
			CMD_SEND: begin
				// window has room: issue next number and clear its count
				if (outstanding < wnd_span) begin
					res.accepted      = 1'b1;
					res.transmit_kind = TX_NEW;
					res.transmit_seq  = 8'(next_seq_q);
					wr_req            = 1'b1;
					wr_addr           = next_seq_q;
					wr_data           = '0;
					if (!timer_q) begin
						res.timer_action = TMR_START;
						res.timer_seq    = 8'(base_q);
						timer_d          = 1'b1;
					end
					next_seq_d = next_seq_q + seq_t'(1);
				end
			end
			CMD_ACK: begin
				if (in_s1.checksum_ok) begin
					if (at_or_below) begin
						// duplicate ack, fast retransmit past the threshold
						wr_req = 1'b1;
						if ((cnt_inc > DUP_THRESHOLD) && (outstanding != '0)) begin
							res.transmit_kind = TX_RETRY;
							res.transmit_seq  = 8'(base_q);
							res.timer_action  = TMR_RESTART;
							res.timer_seq     = 8'(base_q);
							timer_d           = 1'b1;
						end
					end else if (d_ack <= outstanding) begin
						// new ack slides the window
						wr_req = 1'b1;
						end_d  = end_q + d_ack;
						base_d = ack_s1;
						if (next_seq_q != ack_s1) begin
							res.timer_action = TMR_RESTART;
							res.timer_seq    = 8'(ack_s1);
							timer_d          = 1'b1;
						end else begin
							res.timer_action = TMR_STOP;
							res.timer_seq    = 8'(base_q);
							timer_d          = 1'b0;
						end
					end
					// ack of unsent data is dropped
				end
			end
			CMD_EXPIRY: begin
				// only an outstanding packet inside the window is resent
				if (!d_exp[SEQ_BITS-1] && (d_exp < outstanding)) begin
					res.transmit_kind = TX_RETRY;
					res.transmit_seq  = 8'(exp_s1);
					res.timer_action  = TMR_RESTART;
					res.timer_seq     = 8'(exp_s1);
				end
			end
			default: begin
				// unused command code, no change
			end
		endcase

		res.base_now = 8'(base_d);
	end

	// control and sender state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
			next_seq_q  <= '0;
			base_q      <= '0;
			end_q       <= seq_t'(WINDOW_RESET);
			timer_q     <= 1'b0;
			cnt_vld_q   <= '0;
		end else begin
			if (in_accept) begin
				s1_valid_q <= 1'b1;
			end else if (s1_fire) begin
				s1_valid_q <= 1'b0;
			end

			if (s1_fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			if (s1_fire) begin
				next_seq_q <= next_seq_d;
				base_q     <= base_d;
				timer_q    <= timer_d;
			end

			// register write re-anchors the window end on the current base
			if (cfg_wr_en) begin
				end_q <= seq_t'(base_q + seq_t'(cfg_wr_data));
			end else if (s1_fire) begin
				end_q <= end_d;
			end

			if (wr_en) begin
				cnt_vld_q[wr_addr] <= 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_accept) begin
			in_s1       <= in_data;
			cnt_vld_s1  <= cnt_vld_q[rd_addr];
			// catch the write that lands on the same edge as this read
			fwd_hit_s1  <= wr_en && (wr_addr == rd_addr);
			fwd_data_s1 <= wr_data;
		end
		if (s1_fire) begin
			out_q <= res;
		end
	end

	// packets in flight always have a timer running
	`SWS_ASSERT(a_timer_when_outstanding, clk, arst_n, (next_seq_q != base_q) |-> timer_q, "outstanding packets without running timer")

	// a held stage keeps its item
	`SWS_ASSERT(a_s1_hold, clk, arst_n, (s1_valid_q && !s1_fire) |=> (s1_valid_q && $stable(in_s1)), "stage 1 item changed while held")

	// an accepted send always carries a new packet and never a timer stop or restart
	`SWS_NEVER(a_accept_kind, clk, arst_n, out_valid_q && out_q.accepted && ((out_q.transmit_kind != TX_NEW) || (out_q.timer_action == TMR_STOP) || (out_q.timer_action == TMR_RESTART)), "accepted send with wrong commands")

endmodule

`default_nettype wire

>>> rtl/swsfr_ram.sv
// ----------------------------------------------------------------------------
// swsfr_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module swsfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read returns the old word on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire
